// ----- hdl/sebq_pkg.sv -----
// Shared types and constants for the scroll encoder and button qualifier.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package sebq_pkg;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] KIND_POLL   = 2'd0;
    localparam logic [1:0] KIND_APPLY  = 2'd1;
    localparam logic [1:0] KIND_ATTACH = 2'd2;

    // Bit positions in the pending event register.
    localparam int EV_ESC  = 0;
    localparam int EV_SEL  = 1;
    localparam int EV_PREV = 2;
    localparam int EV_NEXT = 3;

    // LED command codes.
    localparam logic [1:0] LED_NONE  = 2'd0;
    localparam logic [1:0] LED_IDLE  = 2'd1;
    localparam logic [1:0] LED_PRESS = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_INVERT   = 3'd0;
    localparam logic [2:0] REG_HORIZ    = 3'd1;
    localparam logic [2:0] REG_DETENTS  = 3'd2;
    localparam logic [2:0] REG_HOLD     = 3'd3;
    localparam logic [2:0] REG_GLITCH   = 3'd4;
    localparam logic [2:0] REG_IDLE_LIM = 3'd5;
    localparam logic [2:0] REG_FAIL_LIM = 3'd6;

    // Port widths.
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;
    localparam int RES_W      = 17;
    localparam int CFG_DATA_W = 16;

    // Saturation limit of the fail and idle counters.
    localparam logic [7:0] CNT_MAX = 8'd255;

    // Configuration register set.
    typedef struct packed {
        logic        invert;
        logic        horiz;
        logic [7:0]  detents;
        logic [15:0] hold_ms;
        logic [6:0]  glitch;
        logic [7:0]  idle_lim;
        logic [7:0]  fail_lim;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic div_step;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_needed;
        logic div_done;
    } t_sts;

endpackage

// ----- hdl/sebq_ctrl.sv -----
// Controller state machine for the scroll encoder and button qualifier.
// Depends on sebq_pkg for the command and status structs.
`timescale 1ns / 1ps

module sebq_ctrl import sebq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // The output register may be reloaded when empty or emptied this cycle.
    assign out_free = !r_out_valid || i_m_tready;

    // Next state, next output valid and commands.
    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        o_cmd         = '0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.div_needed ? S_DIV : S_FIN;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

// ----- hdl/sebq_dp.sv -----
// Datapath of the scroll encoder and button qualifier: item and state
// registers, the detent divider by repeated subtraction and the result register.
// Depends on sebq_pkg.
`timescale 1ns / 1ps

module sebq_dp import sebq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [1:0]            i_kind,
    input  logic                  i_bus_free,
    input  logic                  i_device_ok,
    input  logic signed [15:0]    i_increment,
    input  logic                  i_button,
    input  logic [31:0]           i_now_ms,
    output logic [RES_W-1:0]      o_result
);

    // Captured input item.
    logic [1:0]         r_kind;
    logic               r_bus_free;
    logic               r_dev_ok;
    logic signed [15:0] r_inc;
    logic               r_button;
    logic [31:0]        r_now;

    // Qualifier state.
    logic               r_present, n_present;
    logic [7:0]         r_fail, n_fail;
    logic signed [9:0]  r_sum, n_sum;
    logic [7:0]         r_idle, n_idle;
    logic               r_down, n_down;
    logic               r_long, n_long;
    logic [31:0]        r_press, n_press;
    logic               r_last, n_last;
    logic [3:0]         r_pend, n_pend;

    // Per-item working registers.
    logic [3:0]         r_events, n_events;
    logic [1:0]         r_led, n_led;
    logic               r_div_pend, n_div_pend;
    logic [8:0]         r_mag;
    logic               r_neg;
    logic [8:0]         r_cnt;
    logic [RES_W-1:0]   r_result;

    // Encoder intermediate values.
    logic [7:0]         step;
    logic signed [15:0] lim;
    logic               in_range;
    logic signed [7:0]  f_inc;
    logic signed [9:0]  sum_new;
    logic [8:0]         mag_new;
    logic               enc_run;
    logic [31:0]        held_ms;
    logic signed [7:0]  delta;
    logic [3:0]         fin_pend;

    // Zero detents per step counts as one.
    assign step = (i_cfg.detents == 8'd0) ? 8'd1 : i_cfg.detents;

    // Glitch rejection and optional inversion; accepted values fit in 8 bits.
    always_comb begin
        lim      = $signed({9'd0, i_cfg.glitch});
        in_range = (r_inc <= lim) && (r_inc >= -lim);
        f_inc    = in_range ? r_inc[7:0] : 8'sd0;
        if (i_cfg.invert) begin
            f_inc = -f_inc;
        end
        sum_new = r_sum + {{2{f_inc[7]}}, f_inc};
        mag_new = sum_new[9] ? 9'(-sum_new) : sum_new[8:0];
    end

    assign enc_run = (r_kind == KIND_POLL) && r_present && r_bus_free && r_dev_ok;
    assign held_ms = r_now - r_press;

    // Item execution: everything except the step division.
    always_comb begin
        n_present  = r_present;
        n_fail     = r_fail;
        n_sum      = r_sum;
        n_idle     = r_idle;
        n_down     = r_down;
        n_long     = r_long;
        n_press    = r_press;
        n_last     = r_last;
        n_pend     = r_pend;
        n_events   = 4'd0;
        n_led      = LED_NONE;
        n_div_pend = 1'b0;
        priority if (r_kind == KIND_ATTACH) begin
            n_present = r_dev_ok;
            n_fail    = 8'd0;
            n_sum     = 10'sd0;
            n_pend    = 4'd0;
            n_down    = 1'b0;
            n_long    = 1'b0;
            n_last    = 1'b0;
            n_led     = r_dev_ok ? LED_IDLE : LED_NONE;
        end else if (r_kind == KIND_APPLY) begin
            if (r_present) begin
                n_events = r_pend;
                n_pend   = 4'd0;
            end
        end else if (r_kind == KIND_POLL && r_present && r_bus_free) begin
            if (!r_dev_ok) begin
                // Failed read: saturating count, device dropped past the limit.
                n_fail = (r_fail < CNT_MAX) ? r_fail + 8'd1 : r_fail;
                if (n_fail > i_cfg.fail_lim) begin
                    n_present = 1'b0;
                end
            end else begin
                n_fail = 8'd0;
                // Encoder accumulation and idle clearing.
                if (f_inc != 8'sd0) begin
                    n_idle     = 8'd0;
                    n_sum      = sum_new;
                    n_div_pend = (mag_new >= {1'b0, step});
                end else if (r_idle < CNT_MAX) begin
                    n_idle = r_idle + 8'd1;
                    if (n_idle > i_cfg.idle_lim) begin
                        n_sum = 10'sd0;
                    end
                end
                // Button timing.
                if (r_button) begin
                    if (!r_down) begin
                        n_down  = 1'b1;
                        n_press = r_now;
                        n_long  = 1'b0;
                    end else if (!r_long && (held_ms >= {16'd0, i_cfg.hold_ms})) begin
                        n_pend[EV_ESC] = 1'b1;
                        n_long         = 1'b1;
                    end
                    n_led = LED_PRESS;
                end else begin
                    if (r_down) begin
                        n_down = 1'b0;
                        if (!r_long) begin
                            n_pend[EV_SEL] = 1'b1;
                        end
                    end
                    if (r_last) begin
                        n_led = LED_IDLE;
                    end
                end
                n_last = r_button;
            end
        end else begin
            // Busy bus, absent device or unused kind: no change.
            n_present = r_present;
        end
    end

    assign o_sts.div_needed = enc_run && n_div_pend;
    assign o_sts.div_done   = (r_mag < {1'b0, step});

    // Step delta or horizontal event from the quotient, saturated to the 8-bit delta.
    always_comb begin
        delta    = 8'sd0;
        fin_pend = r_pend;
        if (r_div_pend) begin
            if (i_cfg.horiz) begin
                if (r_neg) begin
                    fin_pend[EV_NEXT] = 1'b1;
                end else begin
                    fin_pend[EV_PREV] = 1'b1;
                end
            end else if (r_neg) begin
                delta = (r_cnt > 9'd127) ? 8'sd127 : $signed(r_cnt[7:0]);
            end else begin
                delta = (r_cnt > 9'd127) ? 8'sh80 : $signed(-r_cnt[7:0]);
            end
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= 1'b0;
            r_fail     <= 8'd0;
            r_sum      <= 10'sd0;
            r_idle     <= 8'd0;
            r_down     <= 1'b0;
            r_long     <= 1'b0;
            r_press    <= 32'd0;
            r_last     <= 1'b0;
            r_pend     <= 4'd0;
            r_div_pend <= 1'b0;
        end else if (i_cmd.exec) begin
            r_present  <= n_present;
            r_fail     <= n_fail;
            r_sum      <= n_sum;
            r_idle     <= n_idle;
            r_down     <= n_down;
            r_long     <= n_long;
            r_press    <= n_press;
            r_last     <= n_last;
            r_pend     <= n_pend;
            r_div_pend <= n_div_pend;
        end else if (i_cmd.finish) begin
            r_pend <= fin_pend;
            if (r_div_pend) begin
                r_sum <= r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
            end
        end
    end

    // Item capture, divider and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= i_kind;
            r_bus_free <= i_bus_free;
            r_dev_ok   <= i_device_ok;
            r_inc      <= i_increment;
            r_button   <= i_button;
            r_now      <= i_now_ms;
        end
        if (i_cmd.exec) begin
            r_events <= n_events;
            r_led    <= n_led;
            r_mag    <= mag_new;
            r_neg    <= sum_new[9];
            r_cnt    <= 9'd0;
        end else if (i_cmd.div_step) begin
            r_mag <= r_mag - {1'b0, step};
            r_cnt <= r_cnt + 9'd1;
        end
        if (i_cmd.finish) begin
            r_result <= {r_down && r_long, r_led, |r_events, r_events[EV_NEXT],
                         r_events[EV_PREV], r_events[EV_SEL], r_events[EV_ESC],
                         delta, r_present};
        end
    end

    assign o_result = r_result;

endmodule

// ----- hdl/scroll_encoder_button_qualifier_core.sv -----
// m_axis_tvalid rises after an item passes the load, execute and finish states, with a
// divide state before finish when the subtracting divider folds q detent steps (q is at
// most 127, and up to 381 just after detents_per_step has been lowered); an output stall
// holds finish. The next item is taken only once the previous one has left finish.
// A new item is taken while the previous result still waits on the output.
// Reset (i_rst_n low, synchronous) clears control state and loads configuration defaults.
`timescale 1ns / 1ps

module scroll_encoder_button_qualifier_core import sebq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata from bit 0: bus_free, device_ok, increment[15:0], button, now_ms[31:0], zeros
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]            s_axis_tuser,
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata from bit 0: present, step_delta[7:0], esc_event, sel_event, prev_event,
    // next_event, any_key, led_command[1:0], holding, zeros
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg             r_cfg;
    t_cmd             cmd;
    t_sts             sts;
    logic [RES_W-1:0] result;

    assign o_cfg_ready = 1'b1;

    // Configuration registers, written on each configuration transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.invert   <= 1'b0;
            r_cfg.horiz    <= 1'b0;
            r_cfg.detents  <= 8'd1;
            r_cfg.hold_ms  <= 16'd450;
            r_cfg.glitch   <= 7'd32;
            r_cfg.idle_lim <= 8'd40;
            r_cfg.fail_lim <= 8'd25;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_INVERT:   r_cfg.invert   <= i_cfg_data[0];
                REG_HORIZ:    r_cfg.horiz    <= i_cfg_data[0];
                REG_DETENTS:  r_cfg.detents  <= i_cfg_data[7:0];
                REG_HOLD:     r_cfg.hold_ms  <= i_cfg_data;
                REG_GLITCH:   r_cfg.glitch   <= i_cfg_data[6:0];
                REG_IDLE_LIM: r_cfg.idle_lim <= i_cfg_data[7:0];
                REG_FAIL_LIM: r_cfg.fail_lim <= i_cfg_data[7:0];
                default:      r_cfg.invert   <= r_cfg.invert;
            endcase
        end
    end

    // Sequencing of each item.
    sebq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Qualifier state, divider and result register.
    sebq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (s_axis_tuser),
        .i_bus_free  (s_axis_tdata[0]),
        .i_device_ok (s_axis_tdata[1]),
        .i_increment ($signed(s_axis_tdata[17:2])),
        .i_button    (s_axis_tdata[18]),
        .i_now_ms    (s_axis_tdata[50:19]),
        .o_result    (result)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - RES_W){1'b0}}, result};

endmodule
